@@ rtl/core/rpq_pkg.sv @@
package rpq_pkg;

	localparam int NW = 96;
	localparam int DW = 48;
	localparam int QW = 61;
	localparam int AXIS_SH = 42;
	localparam int THR_SH = 46;

	localparam logic [2:0] CFG_PROP = 3'd0;
	localparam logic [2:0] CFG_INTEG = 3'd1;
	localparam logic [2:0] CFG_DERIV = 3'd2;
	localparam logic [2:0] CFG_BOUND = 3'd3;
	localparam logic [2:0] CFG_INERTIA = 3'd4;
	localparam logic [2:0] CFG_ARM = 3'd5;
	localparam logic [2:0] CFG_COEF = 3'd6;

	localparam logic [47:0] PROP_RST = 48'd9895755647232;
	localparam logic [47:0] INTEG_RST = 48'd3298585215744;
	localparam logic [47:0] DERIV_RST = 48'd330717528141;
	localparam logic [47:0] BOUND_RST = 48'd274882101312000;
	localparam logic [59:0] INERTIA_RST = 60'd7954972014547986;
	localparam logic [15:0] ARM_RST = 16'd5243;
	localparam logic [31:0] COEF_RST = 32'd8203;

	// bit k set where the mixer subtracts term k for that motor
	localparam logic [3:0] MIX_NEG [4] = '{4'b0110, 4'b0000, 4'b0101, 4'b0111};

	localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
		logic [15:0] bound;
		logic [19:0] inertia;
	} lane_cfg_t;

	typedef struct packed {
		logic [51:0] mag;
		logic neg;
	} lane_res_t;

endpackage

@@ rtl/core/rpq_cfg_if.sv @@
interface rpq_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/rpq_in_if.sv @@
interface rpq_in_if;
	logic valid;
	logic ready;
	logic op;
	logic signed [31:0] rate_cmd_roll;
	logic signed [31:0] rate_cmd_pitch;
	logic signed [31:0] rate_cmd_yaw;
	logic signed [31:0] thrust_cmd;
	logic signed [31:0] rate_meas_roll;
	logic signed [31:0] rate_meas_pitch;
	logic signed [31:0] rate_meas_yaw;
	logic signed [31:0] accel_meas_roll;
	logic signed [31:0] accel_meas_pitch;
	logic signed [31:0] accel_meas_yaw;
	logic [23:0] time_step;

	modport source (output valid, op, rate_cmd_roll, rate_cmd_pitch, rate_cmd_yaw, thrust_cmd,
		rate_meas_roll, rate_meas_pitch, rate_meas_yaw, accel_meas_roll, accel_meas_pitch,
		accel_meas_yaw, time_step, input ready);
	modport sink (input valid, op, rate_cmd_roll, rate_cmd_pitch, rate_cmd_yaw, thrust_cmd,
		rate_meas_roll, rate_meas_pitch, rate_meas_yaw, accel_meas_roll, accel_meas_pitch,
		accel_meas_yaw, time_step, output ready);
endinterface

@@ rtl/core/rpq_out_if.sv @@
interface rpq_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] motor_one_speed;
	logic signed [31:0] motor_two_speed;
	logic signed [31:0] motor_three_speed;
	logic signed [31:0] motor_four_speed;

	modport source (output valid, motor_one_speed, motor_two_speed, motor_three_speed,
		motor_four_speed, input ready);
	modport sink (input valid, motor_one_speed, motor_two_speed, motor_three_speed,
		motor_four_speed, output ready);
endinterface

@@ rtl/core/rpq_axis.sv @@
module rpq_axis (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic clr,
	input logic signed [31:0] cmd,
	input logic signed [31:0] meas,
	input logic signed [31:0] accel,
	input logic [23:0] dt,
	input rpq_pkg::lane_cfg_t cfg,
	output logic done,
	output rpq_pkg::lane_res_t res
);
	import rpq_pkg::*;

	logic [5:0] v_q;
	logic signed [31:0] integ_q;

	logic signed [32:0] err_s1;
	logic signed [57:0] pdt_s2;
	logic signed [49:0] pkp_s2, pkp_s3, pkp_s4;
	logic signed [48:0] pkd_s2, pkd_s3, pkd_s4;
	logic signed [31:0] integ_s3;
	logic signed [48:0] pki_s4;
	logic signed [31:0] aa_s5;
	logic signed [52:0] prod_s6;

	logic signed [57:0] rnd;
	logic signed [34:0] isum, bnd;
	logic signed [31:0] integ_c;
	logic signed [51:0] sum, sum_r;
	logic signed [43:0] aa_w;
	logic signed [52:0] prod_abs;

	always_comb begin
		rnd = pdt_s2 + 58'sd8388608;
		isum = 35'(integ_q) + 35'($signed(rnd[57:24]));
		bnd = $signed({9'b0, cfg.bound, 10'b0});
		if (isum < -bnd) begin
			integ_c = 32'(-bnd);
		end else if (isum > bnd) begin
			integ_c = 32'(bnd);
		end else begin
			integ_c = isum[31:0];
		end
		sum = 52'(pkp_s4) + 52'(pki_s4) - 52'(pkd_s4);
		sum_r = sum + 52'sd128;
		aa_w = sum_r[51:8];
		prod_abs = prod_s6[52] ? -prod_s6 : prod_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			integ_q <= '0;
		end else begin
			v_q <= {v_q[4:0], start};
			if (clr) begin
				integ_q <= '0;
			end else if (v_q[1]) begin
				integ_q <= integ_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		err_s1 <= 33'(cmd) - 33'(meas);
		pdt_s2 <= err_s1 * $signed({1'b0, dt});
		pkp_s2 <= $signed({1'b0, cfg.kp}) * err_s1;
		pkd_s2 <= $signed({1'b0, cfg.kd}) * accel;
		// hold the updated integrator so later stages stay put
		if (v_q[1]) begin
			integ_s3 <= integ_c;
		end
		pkp_s3 <= pkp_s2;
		pkd_s3 <= pkd_s2;
		pki_s4 <= $signed({1'b0, cfg.ki}) * integ_s3;
		pkp_s4 <= pkp_s3;
		pkd_s4 <= pkd_s3;
		if (aa_w > 44'sd2147483647) begin
			aa_s5 <= 32'sh7FFF_FFFF;
		end else if (aa_w < -44'sd2147483648) begin
			aa_s5 <= 32'sh8000_0000;
		end else begin
			aa_s5 <= aa_w[31:0];
		end
		prod_s6 <= $signed({1'b0, cfg.inertia}) * aa_s5;
	end

	assign done = v_q[5];
	assign res.mag = prod_abs[51:0];
	assign res.neg = prod_s6[52];

endmodule

@@ rtl/core/rpq_div.sv @@
module rpq_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [rpq_pkg::NW-1:0] n,
	input logic [rpq_pkg::DW-1:0] d,
	output logic done,
	output logic [rpq_pkg::QW-1:0] q
);
	import rpq_pkg::*;

	localparam int CW = $clog2(QW);

	logic busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] nlo_q, q_q;
	logic [DW:0] t;

	assign t = {rem_q, nlo_q[QW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				// zero numerator and quotient overflow finish at once
				if (n == '0 || DW'(n[NW-1:QW]) >= d) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(n[NW-1:QW]);
			nlo_q <= n[QW-1:0];
			if (n == '0) begin
				q_q <= '0;
			end else if (DW'(n[NW-1:QW]) >= d) begin
				q_q <= '1;
			end else begin
				q_q <= '0;
			end
		end else if (busy_q) begin
			nlo_q <= {nlo_q[QW-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				rem_q <= DW'(t - {1'b0, d});
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= t[DW-1:0];
				q_q <= {q_q[QW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign q = q_q;

endmodule

@@ rtl/core/rpq_sqrt.sv @@
module rpq_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] v,
	output logic done,
	output logic [31:0] r
);
	logic busy_q, done_q;
	logic [4:0] cnt_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [63:0] vs_q;
	logic [35:0] t, trial;

	assign t = {rem_q[33:0], vs_q[63:62]};
	assign trial = {2'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// two radicand bits per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			root_q <= '0;
			vs_q <= v;
		end else if (busy_q) begin
			vs_q <= {vs_q[61:0], 2'b00};
			if (t >= trial) begin
				rem_q <= t - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q <= t;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign r = root_q;

endmodule

@@ rtl/core/pid_rate_control_quad_mixer.sv @@
// Three-axis rate PID with a quadrotor motor mixer.
// upd carries one update request: op 0 runs the controller, op 1 clears
// the three integrators and gives no result. motors carries the four
// signed motor speed commands of one update. cfg writes the gain, bound,
// inertia, arm and thrust coefficient registers by index; the user is to
// write them only while idle, which the block itself does not enforce.
// Three axis lanes run the PID and inertia scaling side by side, then four
// restoring dividers (three torque terms and thrust) run together, and
// after the sign mixer four square root units run together.
// An update passes 6 lane stages, 61 divider steps and 32 square root
// steps; the divider steps are skipped when all four divisions end at once
// (zero numerator or overflow). One update is in work at a time; a clear
// request is done on acceptance and gives no result.
// upd is taken again as soon as the result sits in the output register.
// If motors stalls, the finished result waits in a hold state until the
// output register is free. Reset empties the pipeline, restores the
// register defaults and zeroes the integrators.
module pid_rate_control_quad_mixer (
	input logic clk,
	input logic arst_n,
	rpq_cfg_if.sink cfg,
	rpq_in_if.sink upd,
	rpq_out_if.source motors
);
	import rpq_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_AXIS = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_MIX = 3'd3;
	localparam logic [2:0] ST_SQRT = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	logic [2:0] st_q;
	logic start_q, div_go_q, sqrt_go_q, ov_q;
	logic [3:0] div_dn_q;

	logic [47:0] prop_q, integ_q, deriv_q, bound_q;
	logic [59:0] inertia_q;
	logic [15:0] arm_q;
	logic [31:0] coef_q;
	logic [47:0] lk_q;

	logic signed [31:0] cmd_q [3];
	logic signed [31:0] meas_q [3];
	logic signed [31:0] accel_q [3];
	logic signed [31:0] thrust_q;
	logic [23:0] dt_q;

	logic [63:0] mix_mag_q [4];
	logic [3:0] mix_neg_q;
	logic signed [31:0] spd_q [4];

	logic acc, clr, load;
	lane_cfg_t lcfg [3];
	lane_res_t lres [3];
	logic [2:0] lane_done;
	logic [3:0] div_done;
	logic [QW-1:0] div_q [4];
	logic [NW-1:0] div_n [4];
	logic [DW-1:0] div_d [4];
	logic [3:0] sq_done;
	logic [31:0] sq_r [4];
	logic [31:0] th_mag;
	logic [3:0] term_neg;
	logic signed [63:0] mix_m [4];
	logic signed [63:0] xt;

	assign acc = upd.valid && upd.ready;
	assign clr = acc && upd.op;
	assign load = (st_q == ST_HOLD) && (!ov_q || motors.ready);
	assign upd.ready = (st_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lcfg[a].kp = prop_q[16*a +: 16];
			lcfg[a].ki = integ_q[16*a +: 16];
			lcfg[a].kd = deriv_q[16*a +: 16];
			lcfg[a].bound = bound_q[16*a +: 16];
			lcfg[a].inertia = inertia_q[20*a +: 20];
			div_n[a] = NW'(lres[a].mag) << AXIS_SH;
			div_d[a] = lk_q;
			term_neg[a] = lres[a].neg;
		end
		th_mag = thrust_q[31] ? 32'(-thrust_q) : 32'(thrust_q);
		div_n[3] = NW'(th_mag) << THR_SH;
		div_d[3] = DW'(coef_q);
		term_neg[3] = thrust_q[31];
	end

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_lane
			rpq_axis u_axis (
				.clk(clk), .arst_n(arst_n), .start(start_q), .clr(clr),
				.cmd(cmd_q[g]), .meas(meas_q[g]), .accel(accel_q[g]), .dt(dt_q),
				.cfg(lcfg[g]), .done(lane_done[g]), .res(lres[g])
			);
		end
		for (g = 0; g < 4; g++) begin : g_div
			rpq_div u_div (
				.clk(clk), .arst_n(arst_n), .start(div_go_q), .n(div_n[g]),
				.d(div_d[g]), .done(div_done[g]), .q(div_q[g])
			);
		end
		for (g = 0; g < 4; g++) begin : g_sqrt
			rpq_sqrt u_sqrt (
				.clk(clk), .arst_n(arst_n), .start(sqrt_go_q), .v(mix_mag_q[g]),
				.done(sq_done[g]), .r(sq_r[g])
			);
		end
	endgenerate

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			mix_m[j] = '0;
			for (int k = 0; k < 4; k++) begin
				xt = term_neg[k] ? -$signed({3'b0, div_q[k]}) : $signed({3'b0, div_q[k]});
				mix_m[j] = MIX_NEG[j][k] ? mix_m[j] - xt : mix_m[j] + xt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			start_q <= 1'b0;
			div_go_q <= 1'b0;
			sqrt_go_q <= 1'b0;
			div_dn_q <= '0;
			ov_q <= 1'b0;
			prop_q <= PROP_RST;
			integ_q <= INTEG_RST;
			deriv_q <= DERIV_RST;
			bound_q <= BOUND_RST;
			inertia_q <= INERTIA_RST;
			arm_q <= ARM_RST;
			coef_q <= COEF_RST;
		end else begin
			start_q <= 1'b0;
			div_go_q <= 1'b0;
			sqrt_go_q <= 1'b0;
			if (cfg.valid) begin
				case (cfg.index)
					CFG_PROP: prop_q <= cfg.data[47:0];
					CFG_INTEG: integ_q <= cfg.data[47:0];
					CFG_DERIV: deriv_q <= cfg.data[47:0];
					CFG_BOUND: bound_q <= cfg.data[47:0];
					CFG_INERTIA: inertia_q <= cfg.data[59:0];
					CFG_ARM: arm_q <= cfg.data[15:0];
					CFG_COEF: coef_q <= cfg.data[31:0];
					default: ;
				endcase
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (motors.ready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (acc && !upd.op) begin
						start_q <= 1'b1;
						st_q <= ST_AXIS;
					end
				end
				ST_AXIS: begin
					if (lane_done[0]) begin
						div_go_q <= 1'b1;
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if ((div_dn_q | div_done) == 4'hF) begin
						div_dn_q <= '0;
						st_q <= ST_MIX;
					end else begin
						div_dn_q <= div_dn_q | div_done;
					end
				end
				ST_MIX: begin
					sqrt_go_q <= 1'b1;
					st_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_done[0]) begin
						st_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q[0] <= upd.rate_cmd_roll;
			cmd_q[1] <= upd.rate_cmd_pitch;
			cmd_q[2] <= upd.rate_cmd_yaw;
			meas_q[0] <= upd.rate_meas_roll;
			meas_q[1] <= upd.rate_meas_pitch;
			meas_q[2] <= upd.rate_meas_yaw;
			accel_q[0] <= upd.accel_meas_roll;
			accel_q[1] <= upd.accel_meas_pitch;
			accel_q[2] <= upd.accel_meas_yaw;
			thrust_q <= upd.thrust_cmd;
			dt_q <= upd.time_step;
		end
		if (start_q) begin
			lk_q <= arm_q * coef_q;
		end
		if (st_q == ST_MIX) begin
			for (int j = 0; j < 4; j++) begin
				mix_neg_q[j] <= mix_m[j][63];
				mix_mag_q[j] <= mix_m[j][63] ? 64'(-mix_m[j]) : 64'(mix_m[j]);
			end
		end
		if (load) begin
			for (int j = 0; j < 4; j++) begin
				if (sq_r[j] > SPEED_MAX) begin
					spd_q[j] <= mix_neg_q[j] ? -$signed(SPEED_MAX) : $signed(SPEED_MAX);
				end else begin
					spd_q[j] <= mix_neg_q[j] ? -$signed(sq_r[j]) : $signed(sq_r[j]);
				end
			end
		end
	end

	assign motors.valid = ov_q;
	assign motors.motor_one_speed = spd_q[0];
	assign motors.motor_two_speed = spd_q[1];
	assign motors.motor_three_speed = spd_q[2];
	assign motors.motor_four_speed = spd_q[3];

`ifndef SYNTHESIS
	a_dn_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_DIV) |-> (div_dn_q == 4'h0))
		else $error("divider done flags set outside divide phase");
	a_lane_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_done != 3'b000) |-> (st_q == ST_AXIS))
		else $error("lane finished outside axis phase");
	a_speed_sat: assert property (@(posedge clk) disable iff (!arst_n)
		motors.valid |-> (motors.motor_one_speed != 32'sh8000_0000
		&& motors.motor_two_speed != 32'sh8000_0000
		&& motors.motor_three_speed != 32'sh8000_0000
		&& motors.motor_four_speed != 32'sh8000_0000))
		else $error("motor speed beyond saturation limit");
`endif

endmodule

@@ tb/rpq_test_if.sv @@
// request payload as the test side sees it
package rpq_test_pkg;
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic op;
		logic signed [31:0] cmd_r, cmd_p, cmd_y, thrust;
		logic signed [31:0] meas_r, meas_p, meas_y;
		logic signed [31:0] acc_r, acc_p, acc_y;
		logic [23:0] dt;
	} upd_req_t;

	typedef struct packed {
		logic signed [31:0] m1, m2, m3, m4;
	} motor_set_t;
endpackage

@@ tb/pid_rate_control_quad_mixer_test.sv @@
module pid_rate_control_quad_mixer_test;
	import rpq_pkg::*;
	import rpq_test_pkg::*;

	localparam longint SQ_MAX = 64'h1FFF_FFFF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	rpq_cfg_if cfg ();
	rpq_in_if upd ();
	rpq_out_if motors ();

	pid_rate_control_quad_mixer dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .upd(upd), .motors(motors)
	);

	// predictor state
	logic [47:0] kp_reg, ki_reg, kd_reg, bound_reg;
	logic [59:0] inertia_reg;
	logic [15:0] arm_reg;
	logic [31:0] coef_reg;
	logic signed [31:0] integ_st [3];

	motor_set_t speed_q [$];
	int fails = 0;
	longint cycles = 0;

	// directed rows: request, expected result where known
	typedef struct {
		upd_req_t req;
		bit known;
		motor_set_t want;
	} row_t;
	row_t rows [$];

	function automatic longint fshift(longint x, int n);
		return x >>> n;
	endfunction

	// floor(mag*2^sh/d) saturated; 128-bit arithmetic suffices
	function automatic longint quot_sat(longint num, int sh, logic [63:0] d);
		logic [127:0] mag, q;
		longint r;
		mag = (num < 0) ? 128'(-num) : 128'(num);
		if (mag == 0) return 0;
		if (d == 0) q = SQ_MAX;
		else begin
			q = (mag << sh) / d;
			if (q > SQ_MAX) q = SQ_MAX;
		end
		r = longint'(q[63:0]);
		return (num < 0) ? -r : r;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else
				res = res >> 1;
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic void apply_cfg(logic [2:0] idx, logic [63:0] v);
		case (idx)
			CFG_PROP: kp_reg = v[47:0];
			CFG_INTEG: ki_reg = v[47:0];
			CFG_DERIV: kd_reg = v[47:0];
			CFG_BOUND: bound_reg = v[47:0];
			CFG_INERTIA: inertia_reg = v[59:0];
			CFG_ARM: arm_reg = v[15:0];
			CFG_COEF: coef_reg = v[31:0];
			default: ;
		endcase
	endfunction

	// returns 1 when the request gives a motor set
	function automatic bit mix_speeds(upd_req_t r, output motor_set_t res);
		longint x [4];
		longint cmd [3], meas [3], acc [3];
		longint err, integ, sum, aa, bnd, m;
		logic [63:0] lk, mg, rt;
		logic signed [31:0] spd [4];
		res = '0;
		if (r.op == OP_CLEAR) begin
			foreach (integ_st[a]) integ_st[a] = 0;
			return 0;
		end
		cmd = '{r.cmd_r, r.cmd_p, r.cmd_y};
		meas = '{r.meas_r, r.meas_p, r.meas_y};
		acc = '{r.acc_r, r.acc_p, r.acc_y};
		lk = 64'(arm_reg) * 64'(coef_reg);
		for (int a = 0; a < 3; a++) begin
			err = cmd[a] - meas[a];
			bnd = longint'(bound_reg[16*a +: 16]) * 1024;
			integ = integ_st[a] + fshift(err * longint'(r.dt) + (64'sd1 <<< 23), 24);
			if (integ < -bnd) integ = -bnd;
			if (integ > bnd) integ = bnd;
			integ_st[a] = 32'(integ);
			sum = longint'(kp_reg[16*a +: 16]) * err + longint'(ki_reg[16*a +: 16]) * integ
				- longint'(kd_reg[16*a +: 16]) * acc[a];
			aa = fshift(sum + 128, 8);
			if (aa > 64'sd2147483647) aa = 64'sd2147483647;
			if (aa < -64'sd2147483648) aa = -64'sd2147483648;
			x[a] = quot_sat(longint'(inertia_reg[20*a +: 20]) * aa, 42, lk);
		end
		x[3] = quot_sat(longint'(r.thrust), 46, 64'(coef_reg));
		for (int j = 0; j < 4; j++) begin
			m = 0;
			for (int k = 0; k < 4; k++) m += MIX_NEG[j][k] ? -x[k] : x[k];
			mg = (m < 0) ? 64'(-m) : 64'(m);
			rt = root64(mg);
			if (rt > 64'(SPEED_MAX)) rt = 64'(SPEED_MAX);
			spd[j] = (m < 0) ? -32'(rt) : 32'(rt);
		end
		res = '{spd[0], spd[1], spd[2], spd[3]};
		return 1;
	endfunction

	// a zero gap keeps valid high so the next request follows at once
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n != 0) upd.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_req(upd_req_t r);
		upd.op <= r.op;
		upd.rate_cmd_roll <= r.cmd_r;
		upd.rate_cmd_pitch <= r.cmd_p;
		upd.rate_cmd_yaw <= r.cmd_y;
		upd.thrust_cmd <= r.thrust;
		upd.rate_meas_roll <= r.meas_r;
		upd.rate_meas_pitch <= r.meas_p;
		upd.rate_meas_yaw <= r.meas_y;
		upd.accel_meas_roll <= r.acc_r;
		upd.accel_meas_pitch <= r.acc_p;
		upd.accel_meas_yaw <= r.acc_y;
		upd.time_step <= r.dt;
		upd.valid <= 1'b1;
		do @(posedge clk); while (!upd.ready);
	endtask

	task automatic push_req(upd_req_t r);
		motor_set_t e;
		send_req(r);
		if (mix_speeds(r, e)) speed_q.push_back(e);
	endtask

	task automatic drain();
		upd.valid <= 1'b0;
		while (speed_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// valid stays high across back to back writes
	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		cfg.index <= idx;
		cfg.data <= v;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		apply_cfg(idx, v);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			3: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
			default: return $urandom();
		endcase
	endfunction

	function automatic upd_req_t rnd_req();
		upd_req_t r;
		r.op = ($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_UPDATE;
		r.cmd_r = rnd_word(); r.cmd_p = rnd_word(); r.cmd_y = rnd_word();
		r.thrust = rnd_word();
		r.meas_r = rnd_word(); r.meas_p = rnd_word(); r.meas_y = rnd_word();
		r.acc_r = rnd_word(); r.acc_p = rnd_word(); r.acc_y = rnd_word();
		r.dt = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 70000));
		return r;
	endfunction

	function automatic upd_req_t flat_req(logic op, logic [31:0] v, logic [23:0] dt);
		return '{op, v, v, v, v, v, v, v, v, v, v, dt};
	endfunction

	// result side: random stall, compare with oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (motors.valid && motors.ready) begin
				if (speed_q.size() == 0) begin
					$error("motor set with no request waiting");
					fails++;
				end else begin
					motor_set_t e;
					e = speed_q.pop_front();
					if (motors.motor_one_speed !== e.m1) begin
						$error("motor_one_speed exp %0d got %0d", e.m1, motors.motor_one_speed);
						fails++;
					end
					if (motors.motor_two_speed !== e.m2) begin
						$error("motor_two_speed exp %0d got %0d", e.m2, motors.motor_two_speed);
						fails++;
					end
					if (motors.motor_three_speed !== e.m3) begin
						$error("motor_three_speed exp %0d got %0d", e.m3,
							motors.motor_three_speed);
						fails++;
					end
					if (motors.motor_four_speed !== e.m4) begin
						$error("motor_four_speed exp %0d got %0d", e.m4,
							motors.motor_four_speed);
						fails++;
					end
				end
			end
			if ($urandom_range(0, 99) < 3) motors.ready <= 1'b0;
			else if (!motors.ready && $urandom_range(0, 9) < 3) motors.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// directed rows with a known result hold under reset settings
	task automatic fill_rows();
		row_t w;
		w = '{flat_req(OP_UPDATE, 32'd0, 24'd0), 1'b1, '0};
		rows.push_back(w);
		w = '{flat_req(OP_UPDATE, 32'h7FFF_FFFF, 24'hFF_FFFF), 1'b0, '0};
		rows.push_back(w);
		w = '{flat_req(OP_UPDATE, 32'h8000_0000, 24'hFF_FFFF), 1'b0, '0};
		rows.push_back(w);
		w = '{flat_req(OP_CLEAR, 32'd0, 24'd0), 1'b0, '0};
		rows.push_back(w);
		w = '{flat_req(OP_UPDATE, 32'd0, 24'd0), 1'b1, '0};
		rows.push_back(w);
		w.req = flat_req(OP_UPDATE, 32'd0, 24'd0);
		w.req.cmd_r = 32'h7FFF_FFFF; w.req.meas_r = 32'h8000_0000; w.req.dt = 24'hFF_FFFF;
		w.known = 1'b0;
		rows.push_back(w);
		w.req = flat_req(OP_UPDATE, 32'd0, 24'd65536);
		w.req.cmd_y = 32'h8000_0000; w.req.meas_y = 32'h7FFF_FFFF;
		w.req.acc_p = 32'h7FFF_FFFF;
		rows.push_back(w);
		w.req = flat_req(OP_UPDATE, 32'd0, 24'd1);
		w.req.thrust = 32'h0001_0000;
		rows.push_back(w);
		w.req = flat_req(OP_UPDATE, 32'd0, 24'd1);
		w.req.thrust = 32'hFFFF_0000;
		rows.push_back(w);
		w.req = flat_req(OP_CLEAR, 32'hFFFF_FFFF, 24'hFF_FFFF);
		rows.push_back(w);
		w.req = flat_req(OP_UPDATE, 32'hFFFF_FFFF, 24'h80_0000);
		rows.push_back(w);
	endtask

	task automatic run_phase(int n);
		cfg.valid <= 1'b0;
		for (int i = 0; i < n; i++) begin
			push_req(rnd_req());
			idle_gap();
		end
		drain();
	endtask

	initial begin
		motor_set_t e;
		cfg.valid = 1'b0; cfg.index = CFG_PROP; cfg.data = '0;
		upd.valid = 1'b0;
		{upd.op, upd.rate_cmd_roll, upd.rate_cmd_pitch, upd.rate_cmd_yaw, upd.thrust_cmd,
			upd.rate_meas_roll, upd.rate_meas_pitch, upd.rate_meas_yaw, upd.accel_meas_roll,
			upd.accel_meas_pitch, upd.accel_meas_yaw, upd.time_step} = '0;
		motors.ready = 1'b1;
		apply_cfg(CFG_PROP, PROP_RST); apply_cfg(CFG_INTEG, INTEG_RST);
		apply_cfg(CFG_DERIV, DERIV_RST); apply_cfg(CFG_BOUND, BOUND_RST);
		apply_cfg(CFG_INERTIA, INERTIA_RST); apply_cfg(CFG_ARM, ARM_RST);
		apply_cfg(CFG_COEF, COEF_RST);
		foreach (integ_st[a]) integ_st[a] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fill_rows();
		foreach (rows[i]) begin
			send_req(rows[i].req);
			if (mix_speeds(rows[i].req, e))
				speed_q.push_back(rows[i].known ? rows[i].want : e);
			idle_gap();
		end
		drain();

		run_phase(200);
		// zero divisors: arm and coefficient zero
		write_reg(CFG_ARM, 64'd0);
		write_reg(CFG_COEF, 64'd0);
		run_phase(60);
		// all ones
		write_reg(CFG_PROP, '1); write_reg(CFG_INTEG, '1); write_reg(CFG_DERIV, '1);
		write_reg(CFG_BOUND, '1); write_reg(CFG_INERTIA, '1); write_reg(CFG_ARM, '1);
		write_reg(CFG_COEF, '1);
		run_phase(120);
		// zero gains, bounds and inertia
		write_reg(CFG_PROP, 64'd0); write_reg(CFG_INTEG, 64'd0); write_reg(CFG_DERIV, 64'd0);
		write_reg(CFG_BOUND, 64'd0); write_reg(CFG_INERTIA, 64'd0);
		run_phase(40);
		for (int p = 0; p < 3; p++) begin
			write_reg(CFG_PROP, {$urandom(), $urandom()});
			write_reg(CFG_INTEG, {$urandom(), $urandom()});
			write_reg(CFG_DERIV, {$urandom(), $urandom()});
			write_reg(CFG_BOUND, {$urandom(), $urandom()});
			write_reg(CFG_INERTIA, {$urandom(), $urandom()});
			write_reg(CFG_ARM, 64'($urandom_range(1, 65535)));
			write_reg(CFG_COEF, 64'($urandom()));
			run_phase(110);
		end

		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
